[hw/rtl/mpd_pkg.sv]
`default_nettype none

package mpd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_DESC  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Configuration register indexes (byte address is four times the index).
  localparam int unsigned REG_MAX_PAYLOAD = 0;
  localparam int unsigned CFG_ADDR_W      = 3;

  // Header layout.
  localparam int unsigned HDR_BYTES  = 6;
  localparam int unsigned TIME_BYTES = 8;
  localparam int unsigned FLAG_KEY   = 47;
  localparam int unsigned FLAG_CTX   = 46;
  localparam int unsigned FLAG_TS    = 45;

  // Absolute payload size limit and register reset value.
  localparam logic [31:0] SIZE_HARD_LIMIT = 32'd8388608;
  localparam logic [23:0] MAX_PAYLOAD_RST = 24'd8388608;

  typedef struct packed {
    logic [7:0]  stream_byte;
    logic [43:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data_byte;
    logic               last;
    logic               is_context;
    logic               is_key_frame;
    logic [12:0]        codec_id;
    logic [23:0]        payload_size;
    logic signed [63:0] timestamp;
  } out_item_t;

  // Result of one parse step.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } parse_res_t;

endpackage

`default_nettype wire

[hw/rtl/mpd_cfg.sv]
`default_nettype none

module mpd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output logic      [23:0]                    max_payload
);
  import mpd_pkg::*;

  logic [23:0] max_payload_r;
  logic [23:0] max_payload_nxt;
  logic        sel_max;

  // Word index decode: the low two address bits select bytes within a word.
  assign sel_max = (paddr[CFG_ADDR_W-1:2] == REG_MAX_PAYLOAD[CFG_ADDR_W-3:0]);

  // Register write on the access phase.
  always_comb begin
    max_payload_nxt = max_payload_r;
    if (psel && penable && pwrite && sel_max) begin
      max_payload_nxt = pwdata[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else begin
      max_payload_r <= max_payload_nxt;
    end
  end

  // Read back.
  assign prdata      = sel_max ? {8'd0, max_payload_r} : 32'd0;
  assign pready      = 1'b1;
  assign max_payload = max_payload_r;

endmodule

`default_nettype wire

[hw/rtl/mpd_parse.sv]
`default_nettype none

module mpd_parse (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire mpd_pkg::in_item_t   item,
  input  wire logic [23:0]         max_payload,
  output mpd_pkg::parse_res_t      res
);
  import mpd_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_TIME    = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DEAD    = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  byte_index_r, byte_index_nxt;
  logic [47:0] header_bits_r, header_bits_nxt;
  logic [63:0] time_bits_r, time_bits_nxt;
  logic [23:0] bytes_left_r, bytes_left_nxt;

  logic [47:0] hdr_shift;
  logic [63:0] time_shift;
  logic [47:0] fin_hdr;
  logic [31:0] fin_size;
  logic        size_bad;
  logic [63:0] ts_now;
  logic        do_finish;

  assign hdr_shift  = {header_bits_r[39:0], item.stream_byte};
  assign time_shift = {time_bits_r[55:0], item.stream_byte};

  // now_ms * 1000 as (x << 10) - (x << 4) - (x << 3).
  assign ts_now = {10'd0, item.now_ms, 10'd0}
                - {16'd0, item.now_ms, 4'd0}
                - {17'd0, item.now_ms, 3'd0};

  // The header word used at completion: just shifted in, or held during the timestamp.
  assign fin_hdr  = (phase_r == PH_HEADER) ? hdr_shift : header_bits_r;
  assign fin_size = fin_hdr[31:0];
  assign size_bad = (fin_size == 32'd0) || (fin_size > {8'd0, max_payload})
                 || (fin_size > SIZE_HARD_LIMIT);

  // Sequencing and result formation for one item.
  always_comb begin
    phase_nxt       = phase_r;
    byte_index_nxt  = byte_index_r;
    header_bits_nxt = header_bits_r;
    time_bits_nxt   = time_bits_r;
    bytes_left_nxt  = bytes_left_r;
    do_finish       = 1'b0;
    res             = '0;

    case (phase_r)
      PH_HEADER: begin
        header_bits_nxt = hdr_shift;
        byte_index_nxt  = byte_index_r + 3'd1;
        if (byte_index_r == 3'(HDR_BYTES - 1)) begin
          byte_index_nxt = 3'd0;
          if (hdr_shift[FLAG_TS]) begin
            time_bits_nxt = 64'd0;
            phase_nxt     = PH_TIME;
          end else begin
            do_finish = 1'b1;
          end
        end
      end
      PH_TIME: begin
        time_bits_nxt  = time_shift;
        byte_index_nxt = byte_index_r + 3'd1;
        if (byte_index_r == 3'(TIME_BYTES - 1)) begin
          do_finish = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res.valid          = 1'b1;
        res.item.kind      = KIND_DATA;
        res.item.data_byte = item.stream_byte;
        if (bytes_left_r <= 24'd1) begin
          res.item.last  = 1'b1;
          bytes_left_nxt = 24'd0;
          byte_index_nxt = 3'd0;
          phase_nxt      = PH_HEADER;
        end else begin
          bytes_left_nxt = bytes_left_r - 24'd1;
        end
      end
      default: begin
      end
    endcase

    // Header complete: emit a descriptor or, for a bad size, an error.
    if (do_finish) begin
      res.valid             = 1'b1;
      res.item.is_context   = fin_hdr[FLAG_CTX];
      res.item.is_key_frame = fin_hdr[FLAG_KEY];
      res.item.codec_id     = fin_hdr[44:32];
      byte_index_nxt        = 3'd0;
      if (size_bad) begin
        res.item.kind = KIND_ERROR;
        phase_nxt     = PH_DEAD;
      end else begin
        res.item.kind         = KIND_DESC;
        res.item.payload_size = fin_size[23:0];
        res.item.timestamp    = fin_hdr[FLAG_TS] ? time_shift : ts_now;
        bytes_left_nxt        = fin_size[23:0];
        phase_nxt             = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      byte_index_r  <= 3'd0;
      header_bits_r <= 48'd0;
      time_bits_r   <= 64'd0;
      bytes_left_r  <= 24'd0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      byte_index_r  <= byte_index_nxt;
      header_bits_r <= header_bits_nxt;
      time_bits_r   <= time_bits_nxt;
      bytes_left_r  <= bytes_left_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/media_packet_deframer.sv]
// An accepted item is held in the input register, and its result is loaded
// into the result register when that register is empty or being drained.
// Throughput: one item per cycle when not stalled; parse state updates per item.
// Reset: synchronous, active low; the parser returns to header search and
// the payload size limit returns to 8388608 bytes. No clearing pass is needed.
`default_nettype none

module media_packet_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire mpd_pkg::in_item_t              in_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output mpd_pkg::out_item_t                  out_item,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  import mpd_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;
  logic        adv;
  logic        fire;
  logic [23:0] max_payload;
  parse_res_t  res;

  mpd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  mpd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (s1_item_r),
    .max_payload (max_payload),
    .res         (res)
  );

  // The result register can take a new value when empty or being drained.
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
    if (adv) begin
      out_valid_nxt = fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
    if (fire && res.valid) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
